### hdl/rtuf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rtuf_pkg;

	localparam logic [7:0]  SLAVE_RESET     = 8'h11;
	localparam logic [7:0]  FC_READ_HOLDING = 8'h03;
	localparam logic [7:0]  FC_WRITE_SINGLE = 8'h06;
	localparam logic [15:0] CRC_INIT        = 16'hFFFF;
	localparam logic [15:0] CRC_POLY        = 16'hA001;
	localparam logic        OP_READ         = 1'b0;
	localparam logic        OP_WRITE        = 1'b1;

	typedef struct packed {
		logic [7:0]  func;
		logic [15:0] reg_address;
		logic [15:0] data_word;
	} req_t;

	// front -> back
	typedef struct packed {
		logic valid;
		req_t req;
	} req_chan_t;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       last;
	} res_t;

	// one byte through CRC-16/Modbus, LSB first
	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
		logic [15:0] acc;
		acc = crc_in ^ {8'h00, data};
		for (int b = 0; b < 8; b++) begin
			if (acc[0]) acc = (acc >> 1) ^ CRC_POLY;
			else acc = acc >> 1;
		end
		return acc;
	endfunction

endpackage

`default_nettype wire

### hdl/rtuf_front.sv
`timescale 1ns / 1ps
`default_nettype none

module rtuf_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  wire logic               op,
	input  wire logic [15:0]        reg_address,
	input  wire logic [15:0]        data_word,
	output rtuf_pkg::req_chan_t     req_out,
	input  wire logic               req_take
);

	rtuf_pkg::req_t mem_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;
	logic           wr_fire;
	logic           rd_fire;
	rtuf_pkg::req_t new_req;

	assign full    = (count_q == 2'd2);
	assign wr_fire = push && !full;
	assign rd_fire = req_take && (count_q != 2'd0);

	always_comb begin
		new_req.func        = (op == rtuf_pkg::OP_WRITE) ? rtuf_pkg::FC_WRITE_SINGLE
		                                                 : rtuf_pkg::FC_READ_HOLDING;
		new_req.reg_address = reg_address;
		new_req.data_word   = data_word;
	end

	always_ff @(posedge clk) begin
		if (wr_fire) mem_q[wr_ptr_q] <= new_req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (wr_fire) wr_ptr_q <= !wr_ptr_q;
			if (rd_fire) rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + {1'b0, wr_fire} - {1'b0, rd_fire};
		end
	end

	assign req_out.valid = (count_q != 2'd0);
	assign req_out.req   = mem_q[rd_ptr_q];

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3) else $error("request queue count out of range");
	a_ptr_match: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd0 || count_q == 2'd2) |-> wr_ptr_q == rd_ptr_q)
		else $error("request queue pointers inconsistent");
	a_take_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_fire && count_q == 2'd1 && !wr_fire) |=> !req_out.valid)
		else $error("request queue did not drain");

endmodule

`default_nettype wire

### hdl/rtuf_back.sv
`timescale 1ns / 1ps
`default_nettype none

module rtuf_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic [7:0]          slave_address,
	input  wire rtuf_pkg::req_chan_t req_in,
	output logic                     req_take,
	output logic                     empty,
	input  wire logic                pop,
	output logic [7:0]               frame_byte,
	output logic                     last
);

	localparam logic [2:0] POS_SLAVE   = 3'd0;
	localparam logic [2:0] POS_FUNC    = 3'd1;
	localparam logic [2:0] POS_ADDR_HI = 3'd2;
	localparam logic [2:0] POS_ADDR_LO = 3'd3;
	localparam logic [2:0] POS_WORD_HI = 3'd4;
	localparam logic [2:0] POS_WORD_LO = 3'd5;
	localparam logic [2:0] POS_CRC_LO  = 3'd6;
	localparam logic [2:0] POS_CRC_HI  = 3'd7;

	logic           busy_q;
	logic [2:0]     idx_q;
	rtuf_pkg::req_t req_q;
	logic [15:0]    crc_q;

	rtuf_pkg::res_t oq_q [2];
	logic           oq_wr_ptr_q;
	logic           oq_rd_ptr_q;
	logic [1:0]     oq_count_q;

	logic           room;
	logic           emit;
	logic           frame_done;
	logic           load;
	logic           oq_rd_fire;
	logic [7:0]     cur_byte;
	logic           crc_upd;

	assign oq_rd_fire = pop && (oq_count_q != 2'd0);
	assign room       = (oq_count_q != 2'd2) || oq_rd_fire;
	assign emit       = busy_q && room;
	assign frame_done = emit && (idx_q == POS_CRC_HI);
	assign load       = req_in.valid && (!busy_q || frame_done);
	assign req_take   = load;

	always_comb begin
		cur_byte = crc_q[15:8];
		crc_upd  = 1'b1;
		case (idx_q)
			POS_SLAVE:   cur_byte = slave_address;
			POS_FUNC:    cur_byte = req_q.func;
			POS_ADDR_HI: cur_byte = req_q.reg_address[15:8];
			POS_ADDR_LO: cur_byte = req_q.reg_address[7:0];
			POS_WORD_HI: cur_byte = req_q.data_word[15:8];
			POS_WORD_LO: cur_byte = req_q.data_word[7:0];
			POS_CRC_LO: begin
				cur_byte = crc_q[7:0];
				crc_upd  = 1'b0;
			end
			default: begin
				cur_byte = crc_q[15:8];
				crc_upd  = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (load) req_q <= req_in.req;
		if (load) crc_q <= rtuf_pkg::CRC_INIT;
		else if (emit && crc_upd) crc_q <= rtuf_pkg::crc_byte(crc_q, cur_byte);
		if (emit) begin
			oq_q[oq_wr_ptr_q].frame_byte <= cur_byte;
			oq_q[oq_wr_ptr_q].last       <= (idx_q == POS_CRC_HI);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			idx_q       <= POS_SLAVE;
			oq_wr_ptr_q <= 1'b0;
			oq_rd_ptr_q <= 1'b0;
			oq_count_q  <= 2'd0;
		end else begin
			if (load) busy_q <= 1'b1;
			else if (frame_done) busy_q <= 1'b0;
			if (load) idx_q <= POS_SLAVE;
			else if (emit) idx_q <= idx_q + 3'd1;
			if (emit) oq_wr_ptr_q <= !oq_wr_ptr_q;
			if (oq_rd_fire) oq_rd_ptr_q <= !oq_rd_ptr_q;
			oq_count_q <= oq_count_q + {1'b0, emit} - {1'b0, oq_rd_fire};
		end
	end

	assign empty      = (oq_count_q == 2'd0);
	assign frame_byte = oq_q[oq_rd_ptr_q].frame_byte;
	assign last       = oq_q[oq_rd_ptr_q].last;

	a_oq_range: assert property (@(posedge clk) disable iff (!arst_n)
		oq_count_q != 2'd3) else $error("result queue count out of range");
	a_load_init: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> busy_q && idx_q == POS_SLAVE && crc_q == rtuf_pkg::CRC_INIT)
		else $error("frame start not initialized");
	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && idx_q != POS_CRC_HI) |-> !load)
		else $error("request taken mid-frame");
	a_idle_idx: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> idx_q == POS_SLAVE) else $error("byte index not reset");

endmodule

`default_nettype wire

### hdl/modbus_rtu_request_framer.sv
// Modbus RTU request framer.
// Input channel: push/full. A request (op, reg_address, data_word) transfers
// at a clock edge with push high and full low. op 0 frames a read holding
// registers request (function 0x03), op 1 a write single register (0x06).
// Result channel: empty/pop. While empty is low, frame_byte/last hold the
// oldest byte; it transfers at an edge with pop high. Each request gives
// eight bytes in transmit order: slave address, function, address hi/lo,
// word hi/lo, CRC-16 lo/hi; last marks the CRC high byte.
// Configuration: cfg_valid/cfg_ready write cfg_slave_address (ready is
// always high); write it only while the block is idle.
// A request is registered in the request queue, then in the serializer,
// then its first byte in the result queue. Throughput: one byte per cycle
// while the result queue has room, frames back to back from the single
// byte serializer. A two-entry request queue lets requests transfer mid-frame.
// Reset: queues empty, slave address 0x11. If pop stays low, the two-entry
// result queue fills, the serializer holds, then the request queue fills
// and full rises; nothing is dropped.
`timescale 1ns / 1ps
`default_nettype none

module modbus_rtu_request_framer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic        op,
	input  wire logic [15:0] reg_address,
	input  wire logic [15:0] data_word,
	output logic             empty,
	input  wire logic        pop,
	output logic [7:0]       frame_byte,
	output logic             last,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [7:0]  cfg_slave_address
);

	logic [7:0]          slave_q;
	rtuf_pkg::req_chan_t req_chan;
	logic                req_take;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_q <= rtuf_pkg::SLAVE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			slave_q <= cfg_slave_address;
		end
	end

	rtuf_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.op          (op),
		.reg_address (reg_address),
		.data_word   (data_word),
		.req_out     (req_chan),
		.req_take    (req_take)
	);

	rtuf_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.slave_address (slave_q),
		.req_in        (req_chan),
		.req_take      (req_take),
		.empty         (empty),
		.pop           (pop),
		.frame_byte    (frame_byte),
		.last          (last)
	);

endmodule

`default_nettype wire
